// ----- hw/rtl/wdpm_pkg.sv -----
// Shared constants, types and the p95 rank helper function for the window delay percentile monitor.
`timescale 1ns / 1ps

package wdpm_pkg;

	localparam int WINDOW_DEPTH = 64;
	localparam int IDX_W        = $clog2(WINDOW_DEPTH);
	localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

	localparam int TIME_W  = 64;
	localparam int DIFF_W  = TIME_W - 1;
	localparam int DELAY_W = 54;
	localparam int OUT_W   = 55;
	localparam int KEY_W   = DELAY_W + IDX_W;

	// divide by 1000, 16 bits of the dividend per step
	localparam int US_PER_MS  = 1000;
	localparam int DIV_CHUNK  = 16;
	localparam int DIV_STEPS  = 4;
	localparam int DIV_NUM_W  = DIV_CHUNK * DIV_STEPS;
	localparam int DIV_REM_W  = $clog2(US_PER_MS);
	localparam int DIV_N_W    = DIV_REM_W + DIV_CHUNK;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
	localparam int DIV_RCP_W  = 27;
	localparam int DIV_SHIFT  = 36;
	localparam int DIV_PROD_W = DIV_N_W + DIV_RCP_W;
	localparam logic [DIV_RCP_W-1:0] DIV_RECIP = 27'd68719477;

	// rank = (count*95 + 99) / 100 - 1, the division by reciprocal
	localparam int PCT_NUM    = 95;
	localparam int PCT_ROUND  = 99;
	localparam int RANK_RCP_W = 18;
	localparam int RANK_SHIFT = 24;
	localparam int RANK_W     = CNT_W + 7;
	localparam int RANK_PW    = RANK_W + RANK_RCP_W;
	localparam logic [RANK_RCP_W-1:0] RANK_RECIP = 18'd167773;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_UPD,
		ST_RES
	} wdpm_state_t;

	typedef struct packed {
		logic             vld;
		logic [KEY_W-1:0] key;
		logic             lt;
	} wdpm_link_t;

	typedef struct packed {
		logic             upd;
		logic             evict;
		logic [KEY_W-1:0] new_key;
		logic [KEY_W-1:0] ev_key;
	} wdpm_bcast_t;

	localparam wdpm_link_t LINK_HEAD = '{vld: 1'b0, key: '0, lt: 1'b1};
	localparam wdpm_link_t LINK_TAIL = '{vld: 1'b0, key: '0, lt: 1'b0};

	function automatic logic [IDX_W-1:0] p95_rank(input logic [CNT_W-1:0] cnt);
		logic [RANK_W-1:0]  t;
		logic [RANK_PW-1:0] p;
		logic [CNT_W-1:0]   q;
		t = RANK_W'(cnt) * RANK_W'(PCT_NUM) + RANK_W'(PCT_ROUND);
		p = RANK_PW'(t) * RANK_PW'(RANK_RECIP);
		q = CNT_W'(p >> RANK_SHIFT);
		return IDX_W'(q - 1'b1);
	endfunction

endpackage

// ----- hw/rtl/wdpm_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module wdpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/wdpm_div.sv -----
// Multi-cycle divide of the time difference by 1000, one 16-bit digit per cycle.
`timescale 1ns / 1ps

module wdpm_div import wdpm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIFF_W-1:0]  dividend,
	output logic               done,
	output logic [DELAY_W-1:0] quotient
);

	logic                  busy_q;
	logic [DIV_CNT_W-1:0]  step_q;
	logic [DIV_NUM_W-1:0]  num_q;
	logic [DIV_REM_W-1:0]  rem_q;
	logic [DIV_NUM_W-1:0]  quo_q;
	logic [DIV_N_W-1:0]    n;
	logic [DIV_PROD_W-1:0] prod;
	logic [DIV_CHUNK-1:0]  q;
	logic [DIV_N_W-1:0]    qk;
	logic [DIV_N_W-1:0]    r;

	always_comb begin
		n    = {rem_q, num_q[DIV_NUM_W-1 -: DIV_CHUNK]};
		prod = DIV_PROD_W'(n) * DIV_PROD_W'(DIV_RECIP);
		q    = prod[DIV_SHIFT +: DIV_CHUNK];
		// q * 1000
		qk   = (DIV_N_W'(q) << 10) - (DIV_N_W'(q) << 4) - (DIV_N_W'(q) << 3);
		r    = n - qk;
	end

	assign done     = busy_q && (step_q == DIV_CNT_W'(DIV_STEPS - 1));
	assign quotient = quo_q[DELAY_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= DIV_NUM_W'(dividend);
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << DIV_CHUNK;
			rem_q <= r[DIV_REM_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-DIV_CHUNK-1:0], q};
		end
	end

endmodule

// ----- hw/rtl/wdpm_cell.sv -----
// One cell of the sorted sample chain: evicts the oldest key and inserts the new one in order.
`timescale 1ns / 1ps

module wdpm_cell import wdpm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  wdpm_bcast_t bc,
	input  wdpm_link_t  from_lo,
	input  wdpm_link_t  from_hi,
	output wdpm_link_t  to_lo,
	output wdpm_link_t  to_hi
);

	logic             vld_q;
	logic [KEY_W-1:0] key_q;
	logic             lt_own;
	logic             keep;
	wdpm_link_t       rm;
	logic             vld_d;
	logic [KEY_W-1:0] key_d;

	always_comb begin
		lt_own = vld_q && (key_q < bc.new_key);
		keep   = !bc.evict || (key_q < bc.ev_key);
		to_lo  = '{vld: vld_q, key: key_q, lt: lt_own};
		// contents after the evicted key is squeezed out
		rm     = keep ? to_lo : from_hi;
		to_hi  = rm;
		if (rm.lt) begin
			vld_d = rm.vld;
			key_d = rm.key;
		end else if (from_lo.lt) begin
			vld_d = 1'b1;
			key_d = bc.new_key;
		end else begin
			vld_d = from_lo.vld;
			key_d = from_lo.key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (bc.upd) begin
			vld_q <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		if (bc.upd) begin
			key_q <= key_d;
		end
	end

endmodule

// ----- hw/rtl/window_delay_percentile_monitor.sv -----
// Top level of the sliding-window frame delay percentile monitor.
//
// Input channel (in_valid/in_ready) takes one event: frame_time_us and current_time_us.
// Events with a negative time or a frame time after the current time are not recorded.
// Output channel (out_valid/out_ready) returns one item per event: sample_taken,
// window_count, delay_p95_ms and delay_max_ms.
// A recorded event passes from accept to out_valid through the divide-by-1000 unit
// (four 16-bit digit steps), the update of the sorted cell chain and the selection of the
// p95 cell into the output register; an ignored event goes straight to the result step.
// A new event is accepted only after the previous result is loaded into the output register.
// The result sits in an output register; the next event is accepted while it waits.
// If out_ready stays low, the following event is processed up to its result and then
// holds until the waiting result is taken.
// Reset clears the window (count 0), the write slot, the maximum and both valids;
// no clearing pass is needed, the block is ready right after reset.
`timescale 1ns / 1ps

module window_delay_percentile_monitor import wdpm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [TIME_W-1:0]  frame_time_us,
	input  logic [TIME_W-1:0]  current_time_us,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               sample_taken,
	output logic [CNT_W-1:0]   window_count,
	output logic [OUT_W-1:0]   delay_p95_ms,
	output logic [OUT_W-1:0]   delay_max_ms
);

	wdpm_state_t        state_q;
	wdpm_state_t        state_d;
	logic               acc;
	logic               take;
	logic [DIFF_W-1:0]  diff;
	logic               div_start;
	logic               div_done;
	logic [DELAY_W-1:0] quotient;
	logic               upd_en;
	logic               res_load;
	logic [DELAY_W-1:0] ev_delay;

	logic [IDX_W-1:0]   slot_q;
	logic [CNT_W-1:0]   count_q;
	logic [DELAY_W-1:0] peak_q;
	logic               taken_q;
	logic               full;

	logic               out_valid_q;
	logic               sample_taken_q;
	logic [CNT_W-1:0]   window_count_q;
	logic [OUT_W-1:0]   delay_p95_q;
	logic [OUT_W-1:0]   delay_max_q;

	logic [IDX_W-1:0]   rank;
	logic [DELAY_W-1:0] p95_val;

	wdpm_bcast_t        bc;
	wdpm_link_t         lo2hi [WINDOW_DEPTH];
	wdpm_link_t         hi2lo [WINDOW_DEPTH];

	assign take = !frame_time_us[TIME_W-1] && !current_time_us[TIME_W-1]
		&& (current_time_us[DIFF_W-1:0] >= frame_time_us[DIFF_W-1:0]);
	assign diff = current_time_us[DIFF_W-1:0] - frame_time_us[DIFF_W-1:0];
	assign full = (count_q == CNT_W'(WINDOW_DEPTH));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = take ? ST_DIV : ST_RES;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				state_d = ST_RES;
			end
			ST_RES: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		acc       = in_valid && in_ready;
		div_start = acc && take;
		upd_en    = (state_q == ST_UPD);
		res_load  = (state_q == ST_RES) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	wdpm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (diff),
		.done     (div_done),
		.quotient (quotient)
	);

	wdpm_ram #(
		.WIDTH (DELAY_W),
		.DEPTH (WINDOW_DEPTH)
	) u_ring (
		.clk     (clk),
		.wr_en   (upd_en),
		.wr_addr (slot_q),
		.wr_data (quotient),
		.rd_en   (div_start),
		.rd_addr (slot_q),
		.rd_data (ev_delay)
	);

	assign bc = '{
		upd:     upd_en,
		evict:   full,
		new_key: {quotient, slot_q},
		ev_key:  {ev_delay, slot_q}
	};

	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
		wdpm_link_t from_lo;
		wdpm_link_t from_hi;
		if (i == 0) begin : g_head
			assign from_lo = LINK_HEAD;
		end else begin : g_mid_lo
			assign from_lo = lo2hi[i-1];
		end
		if (i == WINDOW_DEPTH - 1) begin : g_tail
			assign from_hi = LINK_TAIL;
		end else begin : g_mid_hi
			assign from_hi = hi2lo[i+1];
		end
		wdpm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.bc      (bc),
			.from_lo (from_lo),
			.from_hi (from_hi),
			.to_lo   (hi2lo[i]),
			.to_hi   (lo2hi[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			count_q <= '0;
			peak_q  <= '0;
			taken_q <= 1'b0;
		end else begin
			if (acc) begin
				taken_q <= take;
			end
			if (upd_en) begin
				slot_q <= (slot_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;
				if (!full) begin
					count_q <= count_q + 1'b1;
				end
				if (quotient > peak_q) begin
					peak_q <= quotient;
				end
			end
		end
	end

	assign rank = p95_rank(count_q);

	always_comb begin
		p95_val = '0;
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			if (rank == IDX_W'(i)) begin
				p95_val = hi2lo[i].key[KEY_W-1 -: DELAY_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			sample_taken_q <= taken_q;
			window_count_q <= count_q;
			delay_p95_q    <= (count_q == '0) ? '0 : OUT_W'(p95_val);
			delay_max_q    <= OUT_W'(peak_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_taken = sample_taken_q;
	assign window_count = window_count_q;
	assign delay_p95_ms = delay_p95_q;
	assign delay_max_ms = delay_max_q;

endmodule

// ----- verif/window_delay_percentile_monitor_tb.sv -----
// Testbench for the window delay percentile monitor: random and directed events, scoreboard check.
`timescale 1ns / 1ps

module window_delay_percentile_monitor_tb import wdpm_pkg::*; ();

	localparam int CLK_HALF    = 2;
	localparam int RESET_CYCLES = 7;
	localparam int PHASE_ITEMS = 380;
	localparam int BURST_ITEMS = 40;
	localparam int HOLD_LEN    = 250;
	localparam int DRAIN_WAIT  = 20;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [TIME_W-1:0] MAX_POS = {1'b0, {(TIME_W-1){1'b1}}};
	localparam logic [TIME_W-1:0] MIN_NEG = {1'b1, {(TIME_W-1){1'b0}}};

	typedef struct {
		logic               taken;
		logic [CNT_W-1:0]   count;
		logic [OUT_W-1:0]   p95;
		logic [OUT_W-1:0]   peak;
	} window_stats_t;

	class delay_window_scoreboard;
		logic [DELAY_W-1:0] delay_ring [WINDOW_DEPTH];
		int unsigned        write_slot;
		int unsigned        filled;
		logic [DELAY_W-1:0] peak_delay;
		window_stats_t      pending_stats [$];
		int unsigned        errors;

		function new();
			write_slot = 0;
			filled     = 0;
			peak_delay = '0;
			errors     = 0;
		endfunction

		function int unsigned pending();
			return pending_stats.size();
		endfunction

		function logic [DELAY_W-1:0] ring_p95();
			logic [DELAY_W-1:0] sorted [WINDOW_DEPTH];
			logic [DELAY_W-1:0] v;
			int unsigned        j;
			int unsigned        rank;
			if (filled == 0)
				return '0;
			for (int unsigned i = 0; i < filled; i++) begin
				v = delay_ring[i];
				j = i;
				while (j > 0 && sorted[j-1] > v) begin
					sorted[j] = sorted[j-1];
					j--;
				end
				sorted[j] = v;
			end
			rank = (filled * PCT_NUM + PCT_ROUND) / 100 - 1;
			return sorted[rank];
		endfunction

		function void note_event(logic [TIME_W-1:0] frame, logic [TIME_W-1:0] now);
			window_stats_t      s;
			logic [TIME_W-1:0]  diff;
			logic [DELAY_W-1:0] d;
			s.taken = !frame[TIME_W-1] && !now[TIME_W-1] && (now >= frame);
			if (s.taken) begin
				diff = now - frame;
				d = DELAY_W'(diff / TIME_W'(US_PER_MS));
				delay_ring[write_slot] = d;
				write_slot = (write_slot + 1) % WINDOW_DEPTH;
				if (filled < WINDOW_DEPTH)
					filled++;
				if (d > peak_delay)
					peak_delay = d;
			end
			s.count = CNT_W'(filled);
			s.p95   = OUT_W'(ring_p95());
			s.peak  = (filled > 0) ? OUT_W'(peak_delay) : '0;
			pending_stats.push_back(s);
		endfunction

		function void check_result(logic taken, logic [CNT_W-1:0] count,
				logic [OUT_W-1:0] p95, logic [OUT_W-1:0] peak);
			window_stats_t s;
			if (pending_stats.size() == 0) begin
				$display("%0t: unexpected result taken=%b count=%0d p95=%0d max=%0d",
					$time, taken, count, p95, peak);
				errors++;
				return;
			end
			s = pending_stats.pop_front();
			if (taken !== s.taken) begin
				$display("%0t: sample_taken exp %b got %b", $time, s.taken, taken);
				errors++;
			end
			if (count !== s.count) begin
				$display("%0t: window_count exp %0d got %0d", $time, s.count, count);
				errors++;
			end
			if (p95 !== s.p95) begin
				$display("%0t: delay_p95_ms exp %0d got %0d", $time, s.p95, p95);
				errors++;
			end
			if (peak !== s.peak) begin
				$display("%0t: delay_max_ms exp %0d got %0d", $time, s.peak, peak);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [TIME_W-1:0]  frame_time_us = '0;
	logic [TIME_W-1:0]  current_time_us = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               sample_taken;
	logic [CNT_W-1:0]   window_count;
	logic [OUT_W-1:0]   delay_p95_ms;
	logic [OUT_W-1:0]   delay_max_ms;

	delay_window_scoreboard sb = new();
	int                     send_idle_pct = 0;
	int                     recv_idle_pct = 0;
	int                     hold_cycles = 0;
	int unsigned            cycle_count = 0;

	window_delay_percentile_monitor i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.frame_time_us   (frame_time_us),
		.current_time_us (current_time_us),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.sample_taken    (sample_taken),
		.window_count    (window_count),
		.delay_p95_ms    (delay_p95_ms),
		.delay_max_ms    (delay_max_ms)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: random back-pressure, long hold-off when requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				hold_cycles--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_event(frame_time_us, current_time_us);
		if (arst_n && out_valid && out_ready)
			sb.check_result(sample_taken, window_count, delay_p95_ms, delay_max_ms);
	end

	function automatic logic [TIME_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_event(input logic [TIME_W-1:0] frame, input logic [TIME_W-1:0] now);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		frame_time_us   <= frame;
		current_time_us <= now;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic send_random_event();
		logic [TIME_W-1:0] d;
		logic [TIME_W-1:0] span;
		logic [TIME_W-1:0] frame;
		logic [TIME_W-1:0] now;
		int unsigned       k;
		if ($urandom_range(99) < 80) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4: d = $urandom_range(20000);
				5, 6:          d = $urandom;
				7, 8:          d = (rand64() & MAX_POS) >> $urandom_range(62);
				default:       d = MAX_POS - $urandom_range(3000);
			endcase
			span = MAX_POS - d + 1;
			frame = (rand64() & MAX_POS) % span;
			if ($urandom_range(3) == 0)
				frame = frame >> $urandom_range(63);
			now = frame + d;
		end else begin
			case ($urandom_range(3))
				0: begin
					frame = rand64();
					now   = rand64();
				end
				1: begin
					k     = $urandom_range(5000, 1);
					now   = (rand64() & MAX_POS) % (MAX_POS - 5000);
					frame = now + k;
				end
				2: begin
					frame = rand64() | MIN_NEG;
					now   = rand64() & MAX_POS;
				end
				default: begin
					frame = rand64() & MAX_POS;
					now   = rand64() | MIN_NEG;
				end
			endcase
		end
		send_event(frame, now);
	endtask

	// the last accepted item is noted at its accept edge, so look from the next edge on
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	initial begin
		send_idle_pct = 14;
		recv_idle_pct = 79;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ignored events on an empty window
		send_event(MIN_NEG, '0);
		send_event('0, MIN_NEG);
		send_event({TIME_W{1'b1}}, {TIME_W{1'b1}});
		send_event(64'd5000, 64'd4999);
		// equal times, sub-millisecond and boundary delays
		send_event(64'd123456, 64'd123456);
		send_event(64'd0, 64'd999);
		send_event(64'd0, 64'd1000);
		send_event(64'd1000, 64'd2999);
		// largest delay and top of the time range
		send_event('0, MAX_POS);
		send_event(MAX_POS, MAX_POS);
		send_event(MAX_POS, '0);
		send_event('0, {TIME_W{1'b1}});
		send_event(64'd7, 64'd7);
		send_event(MAX_POS - 64'd1, MAX_POS);
		send_event(64'd1, MIN_NEG);
		send_event(64'd0, 64'd1000000);
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 14;
					recv_idle_pct = 79;
				end
				1: begin
					send_idle_pct = 79;
					recv_idle_pct = 14;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					hold_cycles = HOLD_LEN;
					for (int i = 0; i < BURST_ITEMS; i++)
						send_random_event();
					wait_drained();
				end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_random_event();
			wait_drained();
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/wdpm_pkg.sv
hw/rtl/wdpm_ram.sv
hw/rtl/wdpm_div.sv
hw/rtl/wdpm_cell.sv
hw/rtl/window_delay_percentile_monitor.sv
verif/window_delay_percentile_monitor_tb.sv
